/* rtl/lav_pkg.sv */
// Shared constants and helpers for the look-at view matrix pipeline.
`default_nettype none

package lav_pkg;

  // Normalization aligns the largest magnitude so its top bit lands at this position.
  localparam int NORM_TOP = 29;
  localparam int MAG_W = NORM_TOP + 1;

  // Square-root datapath: sum of three squares of MAG_W bits fits in ROOT_W - 1 bits.
  localparam int ROOT_W = 63;
  localparam int ROOT_STEPS = 32;

  // Rows of the view matrix.
  localparam int ROWS = 4;
  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP = 2'd1;
  localparam logic [1:0] ROW_BACK = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // Cycles an accepted command keeps the port busy after the accepting edge.
  localparam logic [1:0] HOLD_CYCLES = 2'(ROWS - 1);

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/lav_norm.sv */
// Pipelined fixed-point vector normalizer: align, square-sum, square root, divide.
`default_nettype none

module lav_norm #(
  parameter int IW = 33,
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_vec [3],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [FB+1:0] out_unit [3],
  output logic                 out_ok,
  output logic [SW-1:0]        out_side
);

  localparam int PW = $clog2(IW);
  localparam int MW = lav_pkg::MAG_W;
  localparam int QW = 2 * MW;
  localparam int RW = lav_pkg::ROOT_W;
  localparam int NS = lav_pkg::ROOT_STEPS;
  localparam int LW = MW + 1;
  localparam int DW = MW + FB + 1;
  localparam int DS = FB + 1;

  // Stage A: magnitudes and signs.
  logic          a_valid;
  logic [IW-1:0] a_mag [3];
  logic          a_neg [3];
  logic [SW-1:0] a_side;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_neg[i] <= in_vec[i][IW-1];
      a_mag[i] <= in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
    end
    a_side <= in_side;
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  // Stage B: position of the leading one of the largest magnitude.
  logic [IW-1:0] or_mag;
  logic [PW-1:0] lead;
  logic          b_valid;
  logic [PW-1:0] b_pos;
  logic          b_zero;
  logic [IW-1:0] b_mag [3];
  logic          b_neg [3];
  logic [SW-1:0] b_side;

  always_comb begin
    or_mag = a_mag[0] | a_mag[1] | a_mag[2];
    lead = '0;
    for (int k = 0; k < IW; k++) begin
      if (or_mag[k]) begin
        lead = PW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    b_pos <= lead;
    b_zero <= (or_mag == '0);
    b_mag <= a_mag;
    b_neg <= a_neg;
    b_side <= a_side;
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  // Stage C: shift all three magnitudes together.
  logic [IW-1:0] shifted [3];
  logic          c_valid;
  logic [MW-1:0] c_mag [3];
  logic          c_neg [3];
  logic          c_zero;
  logic [SW-1:0] c_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_pos >= PW'(lav_pkg::NORM_TOP)) begin
        shifted[i] = b_mag[i] >> (b_pos - PW'(lav_pkg::NORM_TOP));
      end else begin
        shifted[i] = b_mag[i] << (PW'(lav_pkg::NORM_TOP) - b_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c_mag[i] <= shifted[i][MW-1:0];
    end
    c_neg <= b_neg;
    c_zero <= b_zero;
    c_side <= b_side;
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  // Stage D: squares.
  logic          d_valid;
  logic [QW-1:0] d_sq [3];
  logic [MW-1:0] d_mag [3];
  logic          d_neg [3];
  logic          d_zero;
  logic [SW-1:0] d_side;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_sq[i] <= QW'(c_mag[i]) * QW'(c_mag[i]);
    end
    d_mag <= c_mag;
    d_neg <= c_neg;
    d_zero <= c_zero;
    d_side <= c_side;
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  // Stage E is entry 0 of the root pipeline: sum of squares.
  logic          r_valid [NS+1];
  logic [RW-1:0] r_rem [NS+1];
  logic [RW-1:0] r_root [NS+1];
  logic [MW-1:0] r_mag [NS+1][3];
  logic          r_neg [NS+1][3];
  logic          r_zero [NS+1];
  logic [SW-1:0] r_side [NS+1];

  always_ff @(posedge clk) begin
    r_rem[0] <= RW'(d_sq[0]) + RW'(d_sq[1]) + RW'(d_sq[2]);
    r_root[0] <= '0;
    r_mag[0] <= d_mag;
    r_neg[0] <= d_neg;
    r_zero[0] <= d_zero;
    r_side[0] <= d_side;
    if (rst) begin
      r_valid[0] <= 1'b0;
    end else begin
      r_valid[0] <= d_valid;
    end
  end

  // One result bit of the integer square root per stage.
  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * k);
    logic [RW-1:0] trial;

    assign trial = r_root[k] + BIT;

    always_ff @(posedge clk) begin
      if (r_rem[k] >= trial) begin
        r_rem[k+1] <= r_rem[k] - trial;
        r_root[k+1] <= (r_root[k] >> 1) + BIT;
      end else begin
        r_rem[k+1] <= r_rem[k];
        r_root[k+1] <= r_root[k] >> 1;
      end
      r_mag[k+1] <= r_mag[k];
      r_neg[k+1] <= r_neg[k];
      r_zero[k+1] <= r_zero[k];
      r_side[k+1] <= r_side[k];
      if (rst) begin
        r_valid[k+1] <= 1'b0;
      end else begin
        r_valid[k+1] <= r_valid[k];
      end
    end
  end

  // Division pipeline: entry 0 forms the rounded numerators.
  logic          v_valid [DS+1];
  logic [DW-1:0] v_rem [DS+1][3];
  logic [DS-1:0] v_q [DS+1][3];
  logic [LW-1:0] v_len [DS+1];
  logic          v_neg [DS+1][3];
  logic          v_zero [DS+1];
  logic [SW-1:0] v_side [DS+1];
  logic [LW-1:0] root_len;

  assign root_len = r_root[NS][LW-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v_rem[0][i] <= (DW'(r_mag[NS][i]) << FB) + DW'(root_len >> 1);
      v_q[0][i] <= '0;
    end
    v_len[0] <= root_len;
    v_neg[0] <= r_neg[NS];
    v_zero[0] <= r_zero[NS];
    v_side[0] <= r_side[NS];
    if (rst) begin
      v_valid[0] <= 1'b0;
    end else begin
      v_valid[0] <= r_valid[NS];
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [DW-1:0] dvs;

    assign dvs = DW'(v_len[j]) << (DS - 1 - j);

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (v_rem[j][i] >= dvs) begin
          v_rem[j+1][i] <= v_rem[j][i] - dvs;
          v_q[j+1][i] <= {v_q[j][i][DS-2:0], 1'b1};
        end else begin
          v_rem[j+1][i] <= v_rem[j][i];
          v_q[j+1][i] <= {v_q[j][i][DS-2:0], 1'b0};
        end
      end
      v_len[j+1] <= v_len[j];
      v_neg[j+1] <= v_neg[j];
      v_zero[j+1] <= v_zero[j];
      v_side[j+1] <= v_side[j];
      if (rst) begin
        v_valid[j+1] <= 1'b0;
      end else begin
        v_valid[j+1] <= v_valid[j];
      end
    end
  end

  // Output stage: restore the signs.
  logic signed [FB+1:0] qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = signed'({1'b0, v_q[DS][i]});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      out_unit[i] <= v_neg[DS][i] ? -qs[i] : qs[i];
    end
    out_ok <= !v_zero[DS];
    out_side <= v_side[DS];
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_valid[DS];
    end
  end

endmodule

`default_nettype wire

/* rtl/look_at_view_matrix.sv */
// Top level of the right-handed look-at view matrix generator.
// Row 0 of each matrix reaches the result ports first and rows 1 to 3 follow it in order,
// back to back. Setups are pipelined: a new one is accepted while earlier ones are still
// in flight, but busy is raised after each accept so that the four output rows of one
// setup never overlap those of the next. The receiver cannot stall.
// Reset (synchronous, active high) empties the pipeline and clears busy and strobe.
`default_nettype none

module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upward_x,
  input  logic signed [31:0] upward_y,
  input  logic signed [31:0] upward_z,
  output logic               strobe,
  output logic [1:0]         row_index,
  output logic signed [31:0] entry_col0,
  output logic signed [31:0] entry_col1,
  output logic signed [31:0] entry_col2,
  output logic signed [31:0] entry_col3,
  output logic               degenerate,
  output logic               last_row
);

  localparam int FB = FRAC_BITS;
  // Width of a unit vector component: magnitude up to 1.0 plus sign.
  localparam int VW = FB + 2;
  // Difference of eye and target.
  localparam int DIFW = 33;
  // Products of f with up, and their differences (the raw side vector).
  localparam int PXW = VW + 32;
  localparam int CW = PXW + 1;
  // Products of two unit components, and the rounded u components.
  localparam int SFW = 2 * VW;
  localparam int UW = FB + 5;
  // Dot products with the eye position.
  localparam int SEW = VW + 32;
  localparam int UEW = UW + 32;
  localparam int TW = FB + 40;
  localparam int SIDE1 = 192;
  localparam int SIDE2 = 3 * VW + 97;
  localparam longint HALF = longint'(1) << (FB - 1);

  // The port is held busy after each accepted command so that the four output rows
  // of one item never overlap those of the next. The pipeline itself never stalls.
  logic       accept;
  logic [1:0] hold;

  assign accept = start && !busy;
  assign busy = (hold != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (accept) begin
      hold <= lav_pkg::HOLD_CYCLES;
    end else if (hold != '0) begin
      hold <= hold - 2'd1;
    end
  end

  // Input stage: capture the beat and form the forward difference.
  logic                   i_valid;
  logic signed [DIFW-1:0] i_d [3];
  logic signed [31:0]     i_eye [3];
  logic signed [31:0]     i_up [3];

  always_ff @(posedge clk) begin
    if (accept) begin
      i_d[0] <= DIFW'(target_x) - DIFW'(eye_x);
      i_d[1] <= DIFW'(target_y) - DIFW'(eye_y);
      i_d[2] <= DIFW'(target_z) - DIFW'(eye_z);
      i_eye[0] <= eye_x;
      i_eye[1] <= eye_y;
      i_eye[2] <= eye_z;
      i_up[0] <= upward_x;
      i_up[1] <= upward_y;
      i_up[2] <= upward_z;
    end
    if (rst) begin
      i_valid <= 1'b0;
    end else begin
      i_valid <= accept;
    end
  end

  // First normalizer: f = normalize(target - eye). Eye and up ride along as sideband.
  logic [SIDE1-1:0] n1_side_in;
  logic [SIDE1-1:0] n1_side;
  logic             n1_valid;
  logic signed [VW-1:0] n1_f [3];
  logic             n1_ok;
  logic signed [31:0] n1_eye [3];
  logic signed [31:0] n1_up [3];

  assign n1_side_in = {i_eye[0], i_eye[1], i_eye[2], i_up[0], i_up[1], i_up[2]};

  lav_norm #(
    .IW(DIFW),
    .FB(FB),
    .SW(SIDE1)
  ) u_norm_fwd (
    .clk(clk),
    .rst(rst),
    .in_valid(i_valid),
    .in_vec(i_d),
    .in_side(n1_side_in),
    .out_valid(n1_valid),
    .out_unit(n1_f),
    .out_ok(n1_ok),
    .out_side(n1_side)
  );

  assign n1_eye[0] = $signed(n1_side[191:160]);
  assign n1_eye[1] = $signed(n1_side[159:128]);
  assign n1_eye[2] = $signed(n1_side[127:96]);
  assign n1_up[0] = $signed(n1_side[95:64]);
  assign n1_up[1] = $signed(n1_side[63:32]);
  assign n1_up[2] = $signed(n1_side[31:0]);

  // Cross product f x up, first the six exact products, then the differences.
  logic                  x_valid;
  logic signed [PXW-1:0] x_p [6];
  logic signed [VW-1:0]  x_f [3];
  logic signed [31:0]    x_eye [3];
  logic                  x_ok;

  always_ff @(posedge clk) begin
    x_p[0] <= PXW'(n1_f[1]) * PXW'(n1_up[2]);
    x_p[1] <= PXW'(n1_f[2]) * PXW'(n1_up[1]);
    x_p[2] <= PXW'(n1_f[2]) * PXW'(n1_up[0]);
    x_p[3] <= PXW'(n1_f[0]) * PXW'(n1_up[2]);
    x_p[4] <= PXW'(n1_f[0]) * PXW'(n1_up[1]);
    x_p[5] <= PXW'(n1_f[1]) * PXW'(n1_up[0]);
    x_f <= n1_f;
    x_eye <= n1_eye;
    x_ok <= n1_ok;
    if (rst) begin
      x_valid <= 1'b0;
    end else begin
      x_valid <= n1_valid;
    end
  end

  logic                 y_valid;
  logic signed [CW-1:0] y_c [3];
  logic signed [VW-1:0] y_f [3];
  logic signed [31:0]   y_eye [3];
  logic                 y_ok;

  always_ff @(posedge clk) begin
    y_c[0] <= CW'(x_p[0]) - CW'(x_p[1]);
    y_c[1] <= CW'(x_p[2]) - CW'(x_p[3]);
    y_c[2] <= CW'(x_p[4]) - CW'(x_p[5]);
    y_f <= x_f;
    y_eye <= x_eye;
    y_ok <= x_ok;
    if (rst) begin
      y_valid <= 1'b0;
    end else begin
      y_valid <= x_valid;
    end
  end

  // Second normalizer: s = normalize(f x up). The forward vector, eye and the
  // first normalizer's status ride along as sideband.
  logic [SIDE2-1:0]     n2_side_in;
  logic [SIDE2-1:0]     n2_side;
  logic                 n2_valid;
  logic signed [VW-1:0] n2_s [3];
  logic                 n2_ok;
  logic signed [VW-1:0] n2_f [3];
  logic signed [31:0]   n2_eye [3];
  logic                 n2_degen;

  assign n2_side_in = {y_f[0], y_f[1], y_f[2], y_eye[0], y_eye[1], y_eye[2], y_ok};

  lav_norm #(
    .IW(CW),
    .FB(FB),
    .SW(SIDE2)
  ) u_norm_side (
    .clk(clk),
    .rst(rst),
    .in_valid(y_valid),
    .in_vec(y_c),
    .in_side(n2_side_in),
    .out_valid(n2_valid),
    .out_unit(n2_s),
    .out_ok(n2_ok),
    .out_side(n2_side)
  );

  assign n2_f[0] = $signed(n2_side[SIDE2-1 -: VW]);
  assign n2_f[1] = $signed(n2_side[SIDE2-1-VW -: VW]);
  assign n2_f[2] = $signed(n2_side[SIDE2-1-2*VW -: VW]);
  assign n2_eye[0] = $signed(n2_side[96:65]);
  assign n2_eye[1] = $signed(n2_side[64:33]);
  assign n2_eye[2] = $signed(n2_side[32:1]);
  // A zero forward vector also forces a zero cross product, but both flags are kept.
  assign n2_degen = !(n2_side[0] && n2_ok);

  // Stage U1: products for u = s x f and for the s and f translations.
  logic                  u1_valid;
  logic signed [SFW-1:0] u1_p [6];
  logic signed [SEW-1:0] u1_se [3];
  logic signed [SEW-1:0] u1_fe [3];
  logic signed [VW-1:0]  u1_s [3];
  logic signed [VW-1:0]  u1_f [3];
  logic signed [31:0]    u1_eye [3];
  logic                  u1_degen;

  always_ff @(posedge clk) begin
    u1_p[0] <= SFW'(n2_s[1]) * SFW'(n2_f[2]);
    u1_p[1] <= SFW'(n2_s[2]) * SFW'(n2_f[1]);
    u1_p[2] <= SFW'(n2_s[2]) * SFW'(n2_f[0]);
    u1_p[3] <= SFW'(n2_s[0]) * SFW'(n2_f[2]);
    u1_p[4] <= SFW'(n2_s[0]) * SFW'(n2_f[1]);
    u1_p[5] <= SFW'(n2_s[1]) * SFW'(n2_f[0]);
    for (int i = 0; i < 3; i++) begin
      u1_se[i] <= SEW'(n2_s[i]) * SEW'(n2_eye[i]);
      u1_fe[i] <= SEW'(n2_f[i]) * SEW'(n2_eye[i]);
    end
    u1_s <= n2_s;
    u1_f <= n2_f;
    u1_eye <= n2_eye;
    u1_degen <= n2_degen;
    if (rst) begin
      u1_valid <= 1'b0;
    end else begin
      u1_valid <= n2_valid;
    end
  end

  // Stage U2: round u, sum the s and f dot products. Rounding adds half an LSB and
  // shifts right arithmetically, which floors toward minus infinity.
  logic signed [SFW:0]  u_diff [3];
  logic                 u2_valid;
  logic signed [UW-1:0] u2_u [3];
  logic signed [TW-1:0] u2_ts;
  logic signed [TW-1:0] u2_tf;
  logic signed [VW-1:0] u2_s [3];
  logic signed [VW-1:0] u2_f [3];
  logic signed [31:0]   u2_eye [3];
  logic                 u2_degen;

  always_comb begin
    u_diff[0] = (SFW+1)'(u1_p[0]) - (SFW+1)'(u1_p[1]) + (SFW+1)'(HALF);
    u_diff[1] = (SFW+1)'(u1_p[2]) - (SFW+1)'(u1_p[3]) + (SFW+1)'(HALF);
    u_diff[2] = (SFW+1)'(u1_p[4]) - (SFW+1)'(u1_p[5]) + (SFW+1)'(HALF);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u2_u[i] <= UW'(u_diff[i] >>> FB);
    end
    u2_ts <= TW'(u1_se[0]) + TW'(u1_se[1]) + TW'(u1_se[2]);
    u2_tf <= TW'(u1_fe[0]) + TW'(u1_fe[1]) + TW'(u1_fe[2]);
    u2_s <= u1_s;
    u2_f <= u1_f;
    u2_eye <= u1_eye;
    u2_degen <= u1_degen;
    if (rst) begin
      u2_valid <= 1'b0;
    end else begin
      u2_valid <= u1_valid;
    end
  end

  // Stage U3: u dot eye products; finish the s and f translations and the
  // rotation entries in their 32-bit output form.
  logic signed [TW-1:0]  ts_r;
  logic signed [TW-1:0]  tf_r;
  logic                  u3_valid;
  logic signed [UEW-1:0] u3_ue [3];
  logic signed [31:0]    u3_ts;
  logic signed [31:0]    u3_tf;
  logic signed [31:0]    u3_s [3];
  logic signed [31:0]    u3_u [3];
  logic signed [31:0]    u3_f [3];
  logic                  u3_degen;

  always_comb begin
    ts_r = (u2_ts + TW'(HALF)) >>> FB;
    tf_r = (u2_tf + TW'(HALF)) >>> FB;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u3_ue[i] <= UEW'(u2_u[i]) * UEW'(u2_eye[i]);
      u3_s[i] <= lav_pkg::sat32(64'(u2_s[i]));
      u3_u[i] <= lav_pkg::sat32(64'(u2_u[i]));
      u3_f[i] <= lav_pkg::sat32(-64'(u2_f[i]));
    end
    u3_ts <= lav_pkg::sat32(-64'(ts_r));
    u3_tf <= lav_pkg::sat32(64'(tf_r));
    u3_degen <= u2_degen;
    if (rst) begin
      u3_valid <= 1'b0;
    end else begin
      u3_valid <= u2_valid;
    end
  end

  // Stage U4: sum of the u dot products.
  logic                 u4_valid;
  logic signed [TW-1:0] u4_tu;
  logic signed [31:0]   u4_ts;
  logic signed [31:0]   u4_tf;
  logic signed [31:0]   u4_s [3];
  logic signed [31:0]   u4_u [3];
  logic signed [31:0]   u4_f [3];
  logic                 u4_degen;

  always_ff @(posedge clk) begin
    u4_tu <= TW'(u3_ue[0]) + TW'(u3_ue[1]) + TW'(u3_ue[2]);
    u4_ts <= u3_ts;
    u4_tf <= u3_tf;
    u4_s <= u3_s;
    u4_u <= u3_u;
    u4_f <= u3_f;
    u4_degen <= u3_degen;
    if (rst) begin
      u4_valid <= 1'b0;
    end else begin
      u4_valid <= u3_valid;
    end
  end

  // Stage U5: the finished matrix. These registers load only with a valid item
  // and then hold it while the four rows are sent, since busy spaces the items so
  // that their rows never overlap. A degenerate setup zeroes rows 0 to 2 entirely.
  logic signed [TW-1:0] tu_r;
  logic                 m_valid;
  logic signed [31:0]   m_ts;
  logic signed [31:0]   m_tu;
  logic signed [31:0]   m_tf;
  logic signed [31:0]   m_s [3];
  logic signed [31:0]   m_u [3];
  logic signed [31:0]   m_f [3];
  logic                 m_degen;

  assign tu_r = (u4_tu + TW'(HALF)) >>> FB;

  always_ff @(posedge clk) begin
    if (u4_valid) begin
      for (int i = 0; i < 3; i++) begin
        m_s[i] <= u4_degen ? '0 : u4_s[i];
        m_u[i] <= u4_degen ? '0 : u4_u[i];
        m_f[i] <= u4_degen ? '0 : u4_f[i];
      end
      m_ts <= u4_degen ? '0 : u4_ts;
      m_tf <= u4_degen ? '0 : u4_tf;
      m_tu <= u4_degen ? '0 : lav_pkg::sat32(-64'(tu_r));
      m_degen <= u4_degen;
    end
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= u4_valid;
    end
  end

  // Row sequencer: row 0 goes out the cycle after the matrix is ready, then rows
  // 1 to 3 on the following cycles. Each row is one beat marked by strobe.
  logic       active;
  logic [1:0] row_cnt;
  logic [1:0] sel;

  assign sel = m_valid ? lav_pkg::ROW_SIDE : row_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row_cnt <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= m_valid || active;
      if (m_valid) begin
        active <= 1'b1;
        row_cnt <= lav_pkg::ROW_UP;
      end else if (active) begin
        row_cnt <= row_cnt + 2'd1;
        if (row_cnt == lav_pkg::ROW_LAST) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    row_index <= sel;
    degenerate <= m_degen;
    last_row <= (sel == lav_pkg::ROW_LAST);
    case (sel)
      lav_pkg::ROW_SIDE: begin
        entry_col0 <= m_s[0];
        entry_col1 <= m_s[1];
        entry_col2 <= m_s[2];
        entry_col3 <= m_ts;
      end
      lav_pkg::ROW_UP: begin
        entry_col0 <= m_u[0];
        entry_col1 <= m_u[1];
        entry_col2 <= m_u[2];
        entry_col3 <= m_tu;
      end
      lav_pkg::ROW_BACK: begin
        entry_col0 <= m_f[0];
        entry_col1 <= m_f[1];
        entry_col2 <= m_f[2];
        entry_col3 <= m_tf;
      end
      default: begin
        entry_col0 <= '0;
        entry_col1 <= '0;
        entry_col2 <= '0;
        entry_col3 <= 32'(longint'(1) << FB);
      end
    endcase
  end

endmodule

`default_nettype wire

/* verif/look_at_view_matrix_checker.sv */
// Checker that predicts the look-at view matrix rows and compares them with the block.
module look_at_view_matrix_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upward_x,
  input  logic signed [31:0] upward_y,
  input  logic signed [31:0] upward_z,
  input  logic               strobe,
  input  logic [1:0]         row_index,
  input  logic signed [31:0] entry_col0,
  input  logic signed [31:0] entry_col1,
  input  logic signed [31:0] entry_col2,
  input  logic signed [31:0] entry_col3,
  input  logic               degenerate,
  input  logic               last_row,
  output int                 error_count,
  output int                 rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               degen;
    logic               last;
  } matrix_row_t;

  matrix_row_t expected_rows[$];

  function automatic logic signed [63:0] round_frac(input logic signed [63:0] v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Returns 0 when the vector has zero length.
  function automatic bit unit_vector(input logic signed [63:0] v[3],
                                     output logic signed [63:0] o[3]);
    logic [63:0] m[3];
    logic [63:0] mx, sum, len, q;
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    for (int i = 0; i < 3; i++) o[i] = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  task automatic predict_view_rows();
    logic signed [63:0] eye[3], up[3], d[3], f[3], c[3], s[3], u[3];
    logic signed [63:0] ts, tu, tf;
    bit ok;
    eye = '{eye_x, eye_y, eye_z};
    up = '{upward_x, upward_y, upward_z};
    d = '{64'(target_x) - eye_x, 64'(target_y) - eye_y, 64'(target_z) - eye_z};
    ok = unit_vector(d, f);
    c[0] = f[1] * up[2] - f[2] * up[1];
    c[1] = f[2] * up[0] - f[0] * up[2];
    c[2] = f[0] * up[1] - f[1] * up[0];
    if (ok) ok = unit_vector(c, s);
    if (!ok) begin
      for (int i = 0; i < 3; i++) begin
        f[i] = 0; s[i] = 0; u[i] = 0;
      end
    end else begin
      u[0] = round_frac(s[1] * f[2] - s[2] * f[1]);
      u[1] = round_frac(s[2] * f[0] - s[0] * f[2]);
      u[2] = round_frac(s[0] * f[1] - s[1] * f[0]);
    end
    ts = round_frac(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]);
    tu = round_frac(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]);
    tf = round_frac(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
    expected_rows.push_back('{lav_pkg::ROW_SIDE, lav_pkg::sat32(s[0]), lav_pkg::sat32(s[1]),
                              lav_pkg::sat32(s[2]), lav_pkg::sat32(-ts), !ok, 1'b0});
    expected_rows.push_back('{lav_pkg::ROW_UP, lav_pkg::sat32(u[0]), lav_pkg::sat32(u[1]),
                              lav_pkg::sat32(u[2]), lav_pkg::sat32(-tu), !ok, 1'b0});
    expected_rows.push_back('{lav_pkg::ROW_BACK, lav_pkg::sat32(-f[0]), lav_pkg::sat32(-f[1]),
                              lav_pkg::sat32(-f[2]), lav_pkg::sat32(tf), !ok, 1'b0});
    expected_rows.push_back('{lav_pkg::ROW_LAST, 32'sd0, 32'sd0, 32'sd0,
                              lav_pkg::sat32(64'sd1 <<< FRAC_BITS), !ok, 1'b1});
  endtask

  task automatic compare_row();
    matrix_row_t e;
    if (expected_rows.size() == 0) begin
      $error("Unexpected row %0d with no matrix pending", row_index);
      error_count++;
      return;
    end
    e = expected_rows.pop_front();
    if (row_index !== e.row) begin
      $error("row_index: expected %0d, actual %0d", e.row, row_index); error_count++;
    end
    if (entry_col0 !== e.c0) begin
      $error("entry_col0: expected %0d, actual %0d", e.c0, entry_col0); error_count++;
    end
    if (entry_col1 !== e.c1) begin
      $error("entry_col1: expected %0d, actual %0d", e.c1, entry_col1); error_count++;
    end
    if (entry_col2 !== e.c2) begin
      $error("entry_col2: expected %0d, actual %0d", e.c2, entry_col2); error_count++;
    end
    if (entry_col3 !== e.c3) begin
      $error("entry_col3: expected %0d, actual %0d", e.c3, entry_col3); error_count++;
    end
    if (degenerate !== e.degen) begin
      $error("degenerate: expected %0d, actual %0d", e.degen, degenerate); error_count++;
    end
    if (last_row !== e.last) begin
      $error("last_row: expected %0d, actual %0d", e.last, last_row); error_count++;
    end
  endtask

  initial error_count = 0;
  assign rows_pending = expected_rows.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe === 1'b1) compare_row();
      if (start === 1'b1 && busy === 1'b0) predict_view_rows();
    end
  end
endmodule

/* verif/tb_look_at_view_matrix.sv */
// Testbench top that drives camera setups into the look-at matrix block and gives the verdict.
module tb_look_at_view_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int RANDOM_SETUPS = 450;
  // Longest stretch with nothing accepted: pipeline latency plus four rows plus an idle burst,
  // taken several times over.
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * FRAC_BITS + 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] upward_x = '0, upward_y = '0, upward_z = '0;
  logic strobe;
  logic [1:0] row_index;
  logic signed [31:0] entry_col0, entry_col1, entry_col2, entry_col3;
  logic degenerate, last_row;
  int error_count, rows_pending;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) dut (.*);
  look_at_view_matrix_checker #(.FRAC_BITS(FRAC_BITS)) checker_inst (.*);

  // The watchdog counts cycles in which neither a setup nor a row is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Holds one camera setup on the ports until the block takes the beat, then drops start
  // unless the next beat follows immediately (the caller raises it again in that case).
  task automatic send_setup(input logic signed [31:0] v[9], input bit gap_after);
    eye_x <= v[0]; eye_y <= v[1]; eye_z <= v[2];
    target_x <= v[3]; target_y <= v[4]; target_z <= v[5];
    upward_x <= v[6]; upward_y <= v[7]; upward_z <= v[8];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap_after) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_field(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      2: return $signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000;
      default: return $urandom_range(0, 2) == 0 ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  initial begin
    logic signed [31:0] v[9];
    logic signed [31:0] directed[13][9];
    int mode;
    // Axis-aligned views, extremes, a zero-length forward, a zero up, up along forward.
    directed = '{
      '{0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0},
      '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh10000, 32'sh20000, 32'sh30000,
        0, 32'sh10000, 0},
      '{0, 0, 32'sh50000, 0, 0, 0, 0, 0, 0},
      '{0, 0, 32'sh50000, 0, 0, 0, 0, 0, 32'sh20000},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
        32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000},
      '{32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000, 1,
        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
      '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 32'sh10000, 32'sh1},
      '{1, 0, 0, 0, 0, 0, 0, 0, 1},
      '{0, 0, 0, 1, 1, 1, -1, 1, -1},
      '{-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 0, 0, 0, 0, -32'sh10000},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
        32'sh7fffffff, 1, 1, 0},
      '{-1, -1, -1, -1, -1, -1, -1, -1, -1},
      '{32'sh12345678, 32'sh0, 32'sh0, 32'sh12345678, 32'sh1, 32'sh0, 0, 32'sh10000, 0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      v = directed[i];
      send_setup(v, $urandom_range(0, 2) == 0);
    end
    for (int n = 0; n < RANDOM_SETUPS; n++) begin
      mode = $urandom_range(0, 9);
      foreach (v[k]) v[k] = rand_field(mode < 8 ? mode % 3 : 3);
      // A few parallel or zero cases keep the degenerate path busy.
      if (mode == 8) begin
        v[6] = v[3] - v[0]; v[7] = v[4] - v[1]; v[8] = v[5] - v[2];
      end else if (mode == 9 && $urandom_range(0, 1)) begin
        v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
      end
      // The last stretch of the run has no idling at all.
      send_setup(v, n < RANDOM_SETUPS - 60 && $urandom_range(0, 3) == 0);
    end
    start <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
